FILE: src/rrwl_pkg.sv
`default_nettype none
package rrwl_pkg;

  localparam int RANGE_W = 64;
  localparam int SLOT_W  = 4;
  localparam int BLK_W   = 4;
  localparam logic [BLK_W-1:0] BLK_MAX = '1;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_WAKE  = 1'b1;

  typedef enum logic [3:0] {
    ACT_READ_LOCK    = 4'd0,
    ACT_WRITE_LOCK   = 4'd1,
    ACT_READ_TRY     = 4'd2,
    ACT_WRITE_TRY    = 4'd3,
    ACT_READ_UNLOCK  = 4'd4,
    ACT_WRITE_UNLOCK = 4'd5,
    ACT_DOWNGRADE    = 4'd6,
    ACT_CANCEL       = 4'd7,
    ACT_IS_LOCKED    = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    ST_GRANTED     = 3'd0,
    ST_WAITING     = 3'd1,
    ST_REFUSED     = 3'd2,
    ST_DONE        = 3'd3,
    ST_BAD         = 3'd4,
    ST_NOT_WAITING = 3'd5
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic              overlap;
  } result_t;

  typedef struct packed {
    logic ovl;
    logic newer;
    logic gt_max;
    logic lt_min;
  } cmp_res_t;

endpackage
`default_nettype wire

FILE: src/range_reader_writer_lock_table_unit.sv
// Range reader/writer lock table.
// Input channel in_*: one request per transfer (action, slot, inclusive range).
// Output channel out_*: the reply first, then one wake notice per waiter whose
// blocker count reaches zero, in ascending slot order; out_last_of_run marks the
// final result of a request.
// A request that passes its checks walks the table once through a one-read
// one-write entry memory and one shared range/age comparator, one entry per cycle
// unless a wake notice must wait for the output side. Accepted locks, queries,
// unlocks, downgrades and cancels all walk every entry of the table alike.
// A request rejected on its action, slot or range is answered without a walk;
// a rejected unlock, downgrade or non-waiter cancel first reads its own entry.
// in_stall stays high while a request is in progress. The reply is registered
// onto out_* once the next result is emitted or the request finishes.
// When out_stall holds a result, the walk pauses at the next wake notice; a new
// request can be taken while the last result still waits in the output register.
// Reset (rst_n low, synchronous) empties the table and zeroes the age counter;
// no clearing pass is needed.
`default_nettype none
module range_reader_writer_lock_table_unit import rrwl_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int AGE_BITS      = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         in_action,
  input  wire logic [SLOT_W-1:0]  in_slot,
  input  wire logic [RANGE_W-1:0] in_range_start,
  input  wire logic [RANGE_W-1:0] in_range_end,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_kind,
  output logic [SLOT_W-1:0]       out_target_slot,
  output logic [2:0]              out_status,
  output logic                    out_overlap,
  output logic                    out_last_of_run
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int WORD_W = 2 * RANGE_W + AGE_BITS + 1 + BLK_W;
  localparam logic [CNT_W-1:0] CNT_N = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_CHECK, S_SCAN, S_LOCK_FIN, S_QFIN, S_FINISH
  } state_t;

  typedef enum logic [1:0] {M_COUNT, M_QUERY, M_RELEASE} mode_t;
  typedef enum logic [1:0] {F_ALL, F_WRITERS, F_READERS, F_CANCEL} filt_t;

  state_t               state_r, state_nxt;
  mode_t                mode_r, mode_nxt;
  filt_t                filt_r, filt_nxt;
  logic [3:0]           action_r, action_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [RANGE_W-1:0]   q_s_r, q_s_nxt;
  logic [RANGE_W-1:0]   q_e_r, q_e_nxt;
  logic                 rev_r, rev_nxt;
  logic [AGE_BITS-1:0]  me_age_r, me_age_nxt;
  logic                 me_reader_r, me_reader_nxt;
  logic [CNT_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic                 ev_vld_r, ev_vld_nxt;
  logic [IDX_W-1:0]     ev_idx_r, ev_idx_nxt;
  logic [BLK_W-1:0]     cnt_r, cnt_nxt;
  logic [RANGE_W-1:0]   max_r, max_nxt;
  logic [RANGE_W-1:0]   min_r, min_nxt;
  logic                 any_r, any_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [AGE_BITS-1:0]  age_r, age_nxt;

  logic                 rd_en, wr_en;
  logic [IDX_W-1:0]     rd_addr, wr_addr;
  logic [WORD_W-1:0]    rd_word, wr_word;
  logic [RANGE_W-1:0]   rd_first, rd_final;
  logic [AGE_BITS-1:0]  rd_age;
  logic                 rd_reader;
  logic [BLK_W-1:0]     rd_blk;

  logic [RANGE_W-1:0]   cmp_first, cmp_final;
  cmp_res_t             cmp;

  logic                 emit, emit_ok, flush, flush_ok;
  result_t              emit_res;

  logic [IDX_W-1:0]     slot_idx;
  logic                 slot_ok, lock_reader, lock_try, want_reader;
  logic                 bad_req, pass_filt, dec, wake, hold, ent_valid;

  assign slot_idx    = IDX_W'(slot_r);
  assign slot_ok     = 32'(slot_r) < TABLE_ENTRIES;
  assign lock_reader = (action_r == ACT_READ_LOCK) || (action_r == ACT_READ_TRY);
  assign lock_try    = (action_r == ACT_READ_TRY) || (action_r == ACT_WRITE_TRY);
  assign want_reader = action_r == ACT_READ_UNLOCK;

  assign rd_first  = rd_word[WORD_W-1 -: RANGE_W];
  assign rd_final  = rd_word[WORD_W-1-RANGE_W -: RANGE_W];
  assign rd_age    = rd_word[BLK_W+1 +: AGE_BITS];
  assign rd_reader = rd_word[BLK_W];
  assign rd_blk    = rd_word[BLK_W-1:0];

  assign cmp_first = (state_r == S_QFIN) ? min_r : rd_first;
  assign cmp_final = (state_r == S_QFIN) ? max_r : rd_final;
  assign ent_valid = valid_r[ev_idx_r];

  assign in_stall = state_r != S_IDLE;

  rrwl_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word)
  );

  rrwl_cmp #(
    .AGE_BITS (AGE_BITS)
  ) u_cmp (
    .ent_first (cmp_first),
    .ent_final (cmp_final),
    .ent_age   (rd_age),
    .q_first   (q_s_r),
    .q_final   (q_e_r),
    .me_age    (me_age_r),
    .run_max   (max_r),
    .run_min   (min_r),
    .res       (cmp)
  );

  rrwl_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .emit            (emit),
    .emit_res        (emit_res),
    .flush           (flush),
    .emit_ok         (emit_ok),
    .flush_ok        (flush_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_target_slot (out_target_slot),
    .out_status      (out_status),
    .out_overlap     (out_overlap),
    .out_last_of_run (out_last_of_run)
  );

  always_comb begin
    case (filt_r)
      F_ALL:     pass_filt = 1'b1;
      F_WRITERS: pass_filt = !rd_reader;
      F_READERS: pass_filt = rd_reader;
      F_CANCEL:  pass_filt = !(me_reader_r && rd_reader);
      default:   pass_filt = 1'b0;
    endcase
    dec  = (state_r == S_SCAN) && (mode_r == M_RELEASE) && ev_vld_r && ent_valid &&
           (ev_idx_r != slot_idx) && cmp.ovl && pass_filt && cmp.newer && (rd_blk != '0);
    wake = dec && (rd_blk == BLK_W'(1));
    hold = wake && !emit_ok;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    filt_nxt      = filt_r;
    action_nxt    = action_r;
    slot_nxt      = slot_r;
    q_s_nxt       = q_s_r;
    q_e_nxt       = q_e_r;
    rev_nxt       = rev_r;
    me_age_nxt    = me_age_r;
    me_reader_nxt = me_reader_r;
    scan_cnt_nxt  = scan_cnt_r;
    ev_vld_nxt    = ev_vld_r;
    ev_idx_nxt    = ev_idx_r;
    cnt_nxt       = cnt_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    any_nxt       = any_r;
    valid_nxt     = valid_r;
    age_nxt       = age_r;
    rd_en         = 1'b0;
    rd_addr       = slot_idx;
    wr_en         = 1'b0;
    wr_addr       = slot_idx;
    wr_word       = rd_word;
    emit          = 1'b0;
    flush         = 1'b0;
    bad_req       = 1'b0;
    emit_res      = '{kind: KIND_REPLY, slot: slot_r, status: ST_DONE, overlap: 1'b0};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          action_nxt = in_action;
          slot_nxt   = in_slot;
          q_s_nxt    = in_range_start;
          q_e_nxt    = in_range_end;
          rev_nxt    = in_range_start > in_range_end;
          state_nxt  = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        scan_cnt_nxt = '0;
        ev_vld_nxt   = 1'b0;
        cnt_nxt      = '0;
        any_nxt      = 1'b0;
        max_nxt      = '0;
        min_nxt      = '1;
        if (!slot_ok) begin
          bad_req = 1'b1;
        end else begin
          case (action_r)
            ACT_READ_LOCK, ACT_WRITE_LOCK, ACT_READ_TRY, ACT_WRITE_TRY: begin
              if (valid_r[slot_idx] || rev_r) begin
                bad_req = 1'b1;
              end else begin
                mode_nxt  = M_COUNT;
                state_nxt = S_SCAN;
              end
            end
            ACT_READ_UNLOCK, ACT_WRITE_UNLOCK, ACT_DOWNGRADE, ACT_CANCEL: begin
              rd_en     = 1'b1;
              state_nxt = S_CHECK;
            end
            ACT_IS_LOCKED: begin
              if (rev_r) begin
                bad_req = 1'b1;
              end else begin
                mode_nxt  = M_QUERY;
                state_nxt = S_SCAN;
              end
            end
            default: bad_req = 1'b1;
          endcase
        end
        if (bad_req) begin
          emit            = 1'b1;
          emit_res.status = ST_BAD;
          state_nxt       = S_FINISH;
        end
      end

      S_CHECK: begin
        q_s_nxt       = rd_first;
        q_e_nxt       = rd_final;
        me_age_nxt    = rd_age;
        me_reader_nxt = rd_reader;
        mode_nxt      = M_RELEASE;
        emit          = 1'b1;
        if (action_r == ACT_CANCEL) begin
          if (!valid_r[slot_idx] || (rd_blk == '0)) begin
            emit_res.status = ST_NOT_WAITING;
            state_nxt       = S_FINISH;
          end else begin
            valid_nxt[slot_idx] = 1'b0;
            filt_nxt            = F_CANCEL;
            state_nxt           = S_SCAN;
          end
        end else if (!valid_r[slot_idx] || (rd_blk != '0) || (rd_reader != want_reader)) begin
          emit_res.status = ST_BAD;
          state_nxt       = S_FINISH;
        end else begin
          state_nxt = S_SCAN;
          if (action_r == ACT_DOWNGRADE) begin
            filt_nxt = F_READERS;
            wr_en    = 1'b1;
            wr_word  = {rd_first, rd_final, rd_age, 1'b1, rd_blk};
          end else begin
            valid_nxt[slot_idx] = 1'b0;
            filt_nxt            = want_reader ? F_WRITERS : F_ALL;
          end
        end
      end

      S_SCAN: begin
        case (mode_r)
          M_COUNT: begin
            if (ev_vld_r && ent_valid && cmp.ovl && !(lock_reader && rd_reader) &&
                (cnt_r != BLK_MAX)) begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          M_QUERY: begin
            if (ev_vld_r && ent_valid) begin
              any_nxt = 1'b1;
              if (cmp.gt_max) begin
                max_nxt = rd_final;
              end
              if (cmp.lt_min) begin
                min_nxt = rd_first;
              end
            end
          end
          M_RELEASE: begin
            if (dec && !hold) begin
              wr_en   = 1'b1;
              wr_addr = ev_idx_r;
              wr_word = {rd_first, rd_final, rd_age, rd_reader, rd_blk - 1'b1};
            end
            if (wake && !hold) begin
              emit            = 1'b1;
              emit_res.kind   = KIND_WAKE;
              emit_res.slot   = SLOT_W'(ev_idx_r);
              emit_res.status = ST_GRANTED;
            end
          end
          default: ;
        endcase
        if (!hold) begin
          if (scan_cnt_r < CNT_N) begin
            rd_en        = 1'b1;
            rd_addr      = scan_cnt_r[IDX_W-1:0];
            ev_idx_nxt   = scan_cnt_r[IDX_W-1:0];
            ev_vld_nxt   = 1'b1;
            scan_cnt_nxt = scan_cnt_r + 1'b1;
          end else begin
            ev_vld_nxt = 1'b0;
            if (!ev_vld_r) begin
              case (mode_r)
                M_COUNT: state_nxt = S_LOCK_FIN;
                M_QUERY: state_nxt = S_QFIN;
                default: state_nxt = S_FINISH;
              endcase
            end
          end
        end
      end

      S_LOCK_FIN: begin
        emit      = 1'b1;
        state_nxt = S_FINISH;
        if (lock_try && (cnt_r != '0)) begin
          emit_res.status = ST_REFUSED;
        end else begin
          wr_en               = 1'b1;
          wr_word             = {q_s_r, q_e_r, age_r, lock_reader, cnt_r};
          valid_nxt[slot_idx] = 1'b1;
          age_nxt             = age_r + 1'b1;
          emit_res.status     = (cnt_r != '0) ? ST_WAITING : ST_GRANTED;
        end
      end

      S_QFIN: begin
        emit             = 1'b1;
        emit_res.overlap = any_r && cmp.ovl;
        state_nxt        = S_FINISH;
      end

      S_FINISH: begin
        flush = 1'b1;
        if (flush_ok) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      age_r    <= '0;
      ev_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      age_r    <= age_nxt;
      ev_vld_r <= ev_vld_nxt;
    end
    mode_r      <= mode_nxt;
    filt_r      <= filt_nxt;
    action_r    <= action_nxt;
    slot_r      <= slot_nxt;
    q_s_r       <= q_s_nxt;
    q_e_r       <= q_e_nxt;
    rev_r       <= rev_nxt;
    me_age_r    <= me_age_nxt;
    me_reader_r <= me_reader_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    ev_idx_r    <= ev_idx_nxt;
    cnt_r       <= cnt_nxt;
    max_r       <= max_nxt;
    min_r       <= min_nxt;
    any_r       <= any_nxt;
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in progress");

  a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOCK_FIN |-> !valid_r[slot_idx])
    else $error("lock inserted into an occupied slot");

  a_one_release: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(valid_r) + 1 >= $countones($past(valid_r))))
    else $error("more than one entry released in a cycle");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_CHECK) || (state_r == S_SCAN) || (state_r == S_LOCK_FIN))
    else $error("table write outside an update step");

endmodule
`default_nettype wire

FILE: src/rrwl_ram.sv
`default_nettype none
module rrwl_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 133
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: src/rrwl_cmp.sv
`default_nettype none
module rrwl_cmp import rrwl_pkg::*; #(
  parameter int AGE_BITS = 32
) (
  input  wire logic [RANGE_W-1:0]  ent_first,
  input  wire logic [RANGE_W-1:0]  ent_final,
  input  wire logic [AGE_BITS-1:0] ent_age,
  input  wire logic [RANGE_W-1:0]  q_first,
  input  wire logic [RANGE_W-1:0]  q_final,
  input  wire logic [AGE_BITS-1:0] me_age,
  input  wire logic [RANGE_W-1:0]  run_max,
  input  wire logic [RANGE_W-1:0]  run_min,
  output cmp_res_t                 res
);

  assign res.ovl    = (ent_first <= q_final) && (q_first <= ent_final);
  assign res.newer  = me_age < ent_age;
  assign res.gt_max = ent_final > run_max;
  assign res.lt_min = ent_first < run_min;

endmodule
`default_nettype wire

FILE: src/rrwl_out.sv
`default_nettype none
module rrwl_out import rrwl_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              emit,
  input  wire result_t           emit_res,
  input  wire logic              flush,
  output logic                   emit_ok,
  output logic                   flush_ok,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_kind,
  output logic [SLOT_W-1:0]      out_target_slot,
  output logic [2:0]             out_status,
  output logic                   out_overlap,
  output logic                   out_last_of_run
);

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;
  logic    out_last_r, out_last_nxt;
  logic    pend_v_r, pend_v_nxt;
  result_t pend_r, pend_nxt;
  logic    out_free;

  // one result is held back until the next one shows up or the run is flushed, so the last can be flagged
  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    emit_ok       = !pend_v_r || out_free;
    flush_ok      = pend_v_r && out_free;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    if (emit && emit_ok) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = pend_r;
        out_last_nxt  = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = emit_res;
    end else if (flush && flush_ok) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = pend_r;
      out_last_nxt  = 1'b1;
      pend_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
    pend_r     <= pend_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_res_r.kind;
  assign out_target_slot = out_res_r.slot;
  assign out_status      = out_res_r.status;
  assign out_overlap     = out_res_r.overlap;
  assign out_last_of_run = out_last_r;

endmodule
`default_nettype wire

FILE: sim/range_reader_writer_lock_table_unit_tb.sv
`default_nettype none
module range_reader_writer_lock_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrwl_pkg::*;

  localparam int SLOTS      = 16;
  localparam int LIVE       = 0;
  localparam int PLAN       = 1;
  localparam int RAND_ITEMS = 270;
  localparam int QUIET_FROM = 2000;
  localparam int QUIET_TO   = 4000;
  localparam int HOLD_AT    = 120;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_AT   = 150;
  localparam logic [RANGE_W-1:0] ADDR_MAX = '1;

  typedef enum int {REL_ALL, REL_WRITERS, REL_READERS, REL_CANCEL} release_sel_t;
  typedef enum int {PICK_FREE, PICK_RD_HELD, PICK_WR_HELD, PICK_WAITER} slot_pick_t;

  typedef struct packed {
    logic [SLOTS-1:0]                  valid;
    logic [SLOTS-1:0]                  reader;
    logic [SLOTS-1:0][RANGE_W-1:0]     lo;
    logic [SLOTS-1:0][RANGE_W-1:0]     hi;
    logic [SLOTS-1:0][31:0]            age;
    logic [SLOTS-1:0][BLK_W-1:0]       blockers;
    logic [31:0]                       age_ctr;
  } lock_tbl_t;

  typedef struct packed {
    logic [3:0]         action;
    logic [SLOT_W-1:0]  slot;
    logic [RANGE_W-1:0] lo;
    logic [RANGE_W-1:0] hi;
    logic               drain;
  } lock_req_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic              overlap;
    logic              last;
  } lock_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_action = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic [RANGE_W-1:0] in_range_start = '0;
  logic [RANGE_W-1:0] in_range_end = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_kind;
  logic [SLOT_W-1:0] out_target_slot;
  logic [2:0] out_status;
  logic out_overlap;
  logic out_last_of_run;

  lock_tbl_t tbl [2];
  lock_req_t pending [$];
  lock_res_t lock_results_due [$];
  int n_expected = 0;
  int n_received = 0;
  int n_sent = 0;
  int cyc = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  logic [RANGE_W-1:0] win_base;

  range_reader_writer_lock_table_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_slot        (in_slot),
    .in_range_start (in_range_start),
    .in_range_end   (in_range_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_target_slot(out_target_slot),
    .out_status     (out_status),
    .out_overlap    (out_overlap),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to table w; results go to the due queue for the live table.
  function automatic int apply_request(input int w, input lock_req_t r);
    lock_tbl_t t;
    lock_res_t run [$];
    logic rd, me_rd, scan, any, skip;
    logic [RANGE_W-1:0] max_hi, min_lo;
    release_sel_t sel;
    int i, cnt;
    t = tbl[w];
    scan = 1'b0;
    me_rd = 1'b0;
    sel = REL_ALL;
    case (r.action)
      ACT_READ_LOCK, ACT_WRITE_LOCK, ACT_READ_TRY, ACT_WRITE_TRY: begin
        rd = (r.action == ACT_READ_LOCK || r.action == ACT_READ_TRY);
        if (t.valid[r.slot] || r.lo > r.hi) begin
          run.push_back('{KIND_REPLY, r.slot, ST_BAD, 1'b0, 1'b0});
        end else begin
          cnt = 0;
          for (i = 0; i < SLOTS; i++)
            if (t.valid[i] && t.lo[i] <= r.hi && r.lo <= t.hi[i] && !(rd && t.reader[i]))
              cnt++;
          if ((r.action == ACT_READ_TRY || r.action == ACT_WRITE_TRY) && cnt != 0) begin
            run.push_back('{KIND_REPLY, r.slot, ST_REFUSED, 1'b0, 1'b0});
          end else begin
            t.valid[r.slot] = 1'b1;
            t.lo[r.slot] = r.lo;
            t.hi[r.slot] = r.hi;
            t.reader[r.slot] = rd;
            t.age[r.slot] = t.age_ctr;
            t.blockers[r.slot] = (cnt > int'(BLK_MAX)) ? BLK_MAX : BLK_W'(cnt);
            t.age_ctr = t.age_ctr + 1;
            run.push_back('{KIND_REPLY, r.slot, (cnt != 0) ? ST_WAITING : ST_GRANTED,
                            1'b0, 1'b0});
          end
        end
      end
      ACT_READ_UNLOCK, ACT_WRITE_UNLOCK, ACT_DOWNGRADE: begin
        rd = (r.action == ACT_READ_UNLOCK);
        if (!t.valid[r.slot] || t.blockers[r.slot] != 0 || t.reader[r.slot] != rd) begin
          run.push_back('{KIND_REPLY, r.slot, ST_BAD, 1'b0, 1'b0});
        end else begin
          run.push_back('{KIND_REPLY, r.slot, ST_DONE, 1'b0, 1'b0});
          scan = 1'b1;
          if (r.action == ACT_DOWNGRADE) begin
            sel = REL_READERS;
            t.reader[r.slot] = 1'b1;
          end else begin
            sel = rd ? REL_WRITERS : REL_ALL;
            t.valid[r.slot] = 1'b0;
            t.reader[r.slot] = 1'b0;
          end
        end
      end
      ACT_CANCEL: begin
        if (!t.valid[r.slot] || t.blockers[r.slot] == 0) begin
          run.push_back('{KIND_REPLY, r.slot, ST_NOT_WAITING, 1'b0, 1'b0});
        end else begin
          me_rd = t.reader[r.slot];
          run.push_back('{KIND_REPLY, r.slot, ST_DONE, 1'b0, 1'b0});
          t.valid[r.slot] = 1'b0;
          t.reader[r.slot] = 1'b0;
          t.blockers[r.slot] = '0;
          scan = 1'b1;
          sel = REL_CANCEL;
        end
      end
      ACT_IS_LOCKED: begin
        if (r.lo > r.hi) begin
          run.push_back('{KIND_REPLY, r.slot, ST_BAD, 1'b0, 1'b0});
        end else begin
          any = 1'b0;
          max_hi = '0;
          min_lo = ADDR_MAX;
          for (i = 0; i < SLOTS; i++)
            if (t.valid[i]) begin
              any = 1'b1;
              if (t.hi[i] > max_hi) max_hi = t.hi[i];
              if (t.lo[i] < min_lo) min_lo = t.lo[i];
            end
          run.push_back('{KIND_REPLY, r.slot, ST_DONE,
                          any && r.lo <= max_hi && min_lo <= r.hi, 1'b0});
        end
      end
      default: run.push_back('{KIND_REPLY, r.slot, ST_BAD, 1'b0, 1'b0});
    endcase
    if (scan) begin
      for (i = 0; i < SLOTS; i++) begin
        skip = (i == r.slot) || !t.valid[i] ||
               !(t.lo[i] <= t.hi[r.slot] && t.lo[r.slot] <= t.hi[i]);
        if (sel == REL_WRITERS && t.reader[i]) skip = 1'b1;
        if (sel == REL_READERS && !t.reader[i]) skip = 1'b1;
        if (sel == REL_CANCEL && me_rd && t.reader[i]) skip = 1'b1;
        if (!(t.age[r.slot] < t.age[i]) || t.blockers[i] == 0) skip = 1'b1;
        if (!skip) begin
          t.blockers[i] = t.blockers[i] - 1'b1;
          if (t.blockers[i] == 0)
            run.push_back('{KIND_WAKE, SLOT_W'(i), ST_GRANTED, 1'b0, 1'b0});
        end
      end
    end
    run[run.size()-1].last = 1'b1;
    tbl[w] = t;
    if (w == LIVE)
      foreach (run[k]) lock_results_due.push_back(run[k]);
    return run.size();
  endfunction

  function automatic logic [RANGE_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot(input slot_pick_t want);
    int cand [$];
    logic ok;
    int i;
    for (i = 0; i < SLOTS; i++) begin
      case (want)
        PICK_FREE:    ok = !tbl[PLAN].valid[i];
        PICK_RD_HELD: ok = tbl[PLAN].valid[i] && tbl[PLAN].reader[i] &&
                           tbl[PLAN].blockers[i] == 0;
        PICK_WR_HELD: ok = tbl[PLAN].valid[i] && !tbl[PLAN].reader[i] &&
                           tbl[PLAN].blockers[i] == 0;
        default:      ok = tbl[PLAN].valid[i] && tbl[PLAN].blockers[i] != 0;
      endcase
      if (ok) cand.push_back(i);
    end
    if (cand.size() == 0) return SLOT_W'($urandom_range(0, SLOTS-1));
    return SLOT_W'(cand[$urandom_range(0, cand.size()-1)]);
  endfunction

  task automatic add_item(input logic [3:0] act, input logic [SLOT_W-1:0] slot,
                          input logic [RANGE_W-1:0] lo, input logic [RANGE_W-1:0] hi,
                          input logic drain);
    lock_req_t r;
    r = '{act, slot, lo, hi, drain};
    void'(apply_request(PLAN, r));
    pending.push_back(r);
  endtask

  task automatic add_window_item(input logic [3:0] act, input logic [SLOT_W-1:0] slot,
                                 input logic drain);
    logic [RANGE_W-1:0] lo, hi;
    lo = win_base + RANGE_W'($urandom_range(0, 47));
    hi = lo + RANGE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 60)
                                                    : $urandom_range(0, 15));
    if (hi < lo) hi = ADDR_MAX;
    add_item(act, slot, lo, hi, drain);
  endtask

  initial begin
    int n, roll;
    logic drain;
    logic [RANGE_W-1:0] a, b;
    tbl[LIVE] = '0;
    tbl[PLAN] = '0;

    add_item(ACT_READ_LOCK, 0, '0, ADDR_MAX, 1'b0);
    add_item(ACT_WRITE_LOCK, 15, '0, '0, 1'b0);
    add_item(ACT_READ_LOCK, 1, ADDR_MAX, ADDR_MAX, 1'b0);
    add_item(ACT_READ_LOCK, 0, 10, 20, 1'b0);
    add_item(ACT_WRITE_TRY, 2, 5, 10, 1'b0);
    add_item(ACT_READ_TRY, 3, 9, 8, 1'b0);
    add_item(ACT_IS_LOCKED, 4, '0, ADDR_MAX, 1'b0);
    add_item(ACT_IS_LOCKED, 4, ADDR_MAX, '0, 1'b0);
    add_item(4'd9, 5, '0, '0, 1'b0);
    add_item(4'd15, 15, ADDR_MAX, ADDR_MAX, 1'b0);
    add_item(ACT_READ_UNLOCK, 15, '0, '0, 1'b0);
    add_item(ACT_WRITE_UNLOCK, 0, '0, '0, 1'b0);
    add_item(ACT_DOWNGRADE, 0, '0, '0, 1'b0);
    add_item(ACT_CANCEL, 1, '0, '0, 1'b0);
    add_item(ACT_CANCEL, 5, '0, '0, 1'b0);
    add_item(ACT_WRITE_LOCK, 6, 100, 200, 1'b0);
    add_item(ACT_READ_LOCK, 7, 150, 150, 1'b0);
    add_item(ACT_CANCEL, 6, '0, '0, 1'b0);
    add_item(ACT_READ_UNLOCK, 0, ADDR_MAX, ADDR_MAX, 1'b0);
    add_item(ACT_WRITE_UNLOCK, 15, '0, '0, 1'b0);
    add_item(ACT_WRITE_LOCK, 8, 150, 160, 1'b0);
    add_item(ACT_READ_LOCK, 9, 155, 155, 1'b0);
    add_item(ACT_READ_LOCK, 10, 158, 158, 1'b0);
    add_item(ACT_CANCEL, 9, '0, '0, 1'b0);
    add_item(ACT_READ_UNLOCK, 7, '0, '0, 1'b0);
    add_item(ACT_DOWNGRADE, 8, '0, '0, 1'b0);

    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: win_base = '0;
          1: win_base = ADDR_MAX - 64;
          default: win_base = rand_addr();
        endcase
      end
      drain = (n == DRAIN_AT);
      roll = $urandom_range(0, 99);
      if (roll < 34)
        add_window_item(4'($urandom_range(ACT_READ_LOCK, ACT_WRITE_TRY)),
                        pick_slot(PICK_FREE), drain);
      else if (roll < 52)
        add_item(ACT_READ_UNLOCK, pick_slot(PICK_RD_HELD), rand_addr(), rand_addr(), drain);
      else if (roll < 66)
        add_item(ACT_WRITE_UNLOCK, pick_slot(PICK_WR_HELD), rand_addr(), rand_addr(), drain);
      else if (roll < 72)
        add_item(ACT_DOWNGRADE, pick_slot(PICK_WR_HELD), rand_addr(), rand_addr(), drain);
      else if (roll < 81)
        add_item(ACT_CANCEL, pick_slot(PICK_WAITER), rand_addr(), rand_addr(), drain);
      else if (roll < 88)
        add_window_item(ACT_IS_LOCKED, SLOT_W'($urandom_range(0, SLOTS-1)), drain);
      else begin
        a = rand_addr();
        b = rand_addr();
        if ($urandom_range(0, 1) == 0) begin
          a = win_base + RANGE_W'($urandom_range(0, 40));
          b = a + RANGE_W'($urandom_range(0, 30));
          if (b < a) b = ADDR_MAX;
          if ($urandom_range(0, 3) == 0) {a, b} = {b, a};
        end
        add_item(4'($urandom_range(0, 15)), SLOT_W'($urandom_range(0, SLOTS-1)), a, b, drain);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (lock_results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && lock_results_due.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // request side
  always @(posedge clk) begin
    logic idle;
    idle = !(cyc >= QUIET_FROM && cyc < QUIET_TO) && ($urandom_range(0, 99) < 16);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        n_expected = n_expected + apply_request(LIVE, '{in_action, in_slot, in_range_start,
                                                        in_range_end, 1'b0});
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending.size() != 0 && !idle &&
            !(pending[0].drain && n_received != n_expected)) begin
          in_valid <= 1'b1;
          in_action <= pending[0].action;
          in_slot <= pending[0].slot;
          in_range_start <= pending[0].lo;
          in_range_end <= pending[0].hi;
          void'(pending.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side stall, with one long hold to back the block up
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!held_once && n_sent >= HOLD_AT) begin
      held_once <= 1'b1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !(cyc >= QUIET_FROM && cyc < QUIET_TO) && ($urandom_range(0, 99) < 16);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    lock_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_received <= n_received + 1;
      if (lock_results_due.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual slot %0d status %0d",
                 $time, out_target_slot, out_status);
        mismatches++;
      end else begin
        want = lock_results_due.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("target_slot", want.slot, out_target_slot);
        check_field("status", want.status, out_status);
        check_field("overlap", want.overlap, out_overlap);
        check_field("last_of_run", want.last, out_last_of_run);
      end
    end
  end

endmodule
`default_nettype wire
